[rtl/core/scanline_packbits_encoder_macros.svh]
// Assertion macros shared by the encoder modules
`ifndef SCANLINE_PACKBITS_ENCODER_MACROS_SVH
`define SCANLINE_PACKBITS_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: %m");

// next-cycle implication
`define SPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: %m");

`endif

[rtl/core/spe_pkg.sv]
// Types, constants and codes shared by the scanline PackBits encoder
package spe_pkg;

  localparam int MAX_LINE_BYTES_DEF = 4096;
  localparam int MAX_RUN_DEF       = 128;
  localparam int ROW_WIDTH_W       = 13;
  localparam int CFG_DATA_W        = ROW_WIDTH_W;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd64;
  localparam int RAW_LIMIT         = 8;
  localparam int WIDE_LIMIT        = 250;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [0:0] {
    CFG_FOUR_BIT_PIXELS = 1'b0,
    CFG_ROW_WIDTH       = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_index;
  } in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       row_end;
    logic       pixel_dropped;
  } out_t;

  typedef enum logic [1:0] {
    K_RAW = 2'd0,
    K_RUN = 2'd1,
    K_LIT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_DROP = 2'd1,
    RES_BYTE = 2'd2
  } res_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P4_WR,
    ST_ENC_START,
    ST_FILL_A,
    ST_FILL_L,
    ST_DEC,
    ST_LIT_WR,
    ST_RAW_WR,
    ST_ADV,
    ST_LD,
    ST_CHK,
    ST_HDR,
    ST_VAL,
    ST_CNT_HI,
    ST_CNT_LO,
    ST_CLR_INIT,
    ST_CLR,
    ST_FIN,
    ST_RD_TAKE
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      px_rd4;
    logic      px_wr8;
    logic      px_wr4;
    logic      enc_init;
    logic      win_shift;
    logic      pos_inc;
    logic      win_load;
    logic      dec_run;
    logic      dec_lit;
    logic      lit_wr;
    logic      raw_wr;
    logic      run_inc;
    logic      hdr_wr;
    logic      val_wr;
    logic      cnt_hi;
    logic      cnt_lo;
    logic      clr_init;
    logic      clr_step;
    logic      finish;
    logic      rd_take;
    logic      rd_empty;
    logic      emit;
    res_kind_t res;
  } cmd_t;

  typedef struct packed {
    logic  pending;
    logic  rd_ok;
    logic  pc_lt_w;
    logic  pc_last;
    logic  four;
    logic  fill_done;
    kind_t kind;
    logic  triple;
    logic  pos_lt_len;
    logic  run_more;
    logic  cnt_lt_max;
    logic  wide;
    logic  clr_last;
  } sts_t;

endpackage

[rtl/core/scanline_packbits_encoder.sv]
// Scanline PackBits encoder: top level joining sequencer and datapath
//
// One request at a time: start is taken when busy is low, and every request
// gives exactly one result, shown for one cycle with out_valid; the receiver
// cannot stall it. A 4-bit push does a read-modify-write of the row store,
// and a read goes through a registered queue read. The push that completes
// a row also encodes it: a three-byte window is filled, then run, literal
// and raw bytes are written with their packet headers and, unless the row
// is stored raw, the count; then a sweep clears the written part of the row
// store at one byte per cycle, and the row is closed.
module scanline_packbits_encoder #(
  parameter int MAX_LINE_BYTES = spe_pkg::MAX_LINE_BYTES_DEF,
  parameter int MAX_RUN        = spe_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  spe_pkg::in_t                   in_data,
  output logic                           out_valid,
  output spe_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  spe_pkg::cfg_idx_t              cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data
);

  spe_pkg::cmd_t cmd;
  spe_pkg::sts_t sts;

  spe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_data.mode),
    .busy    (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  spe_dp #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_RUN        (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/spe_ctrl.sv]
// Sequencer for pixel intake, row encoding, store clearing and byte reads
module spe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_mode,
  output logic          busy,
  output spe_pkg::cmd_t cmd_o,
  input  spe_pkg::sts_t sts_i
);

  spe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      spe_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (in_mode == spe_pkg::MODE_READ) begin
            if (sts_i.rd_ok) begin
              state_nxt = spe_pkg::ST_RD_TAKE;
            end else begin
              cmd_o.rd_empty = 1'b1;
              cmd_o.emit     = 1'b1;
              cmd_o.res      = spe_pkg::RES_ZERO;
            end
          end else if (sts_i.pending) begin
            cmd_o.emit = 1'b1;
            cmd_o.res  = spe_pkg::RES_DROP;
          end else if (!sts_i.pc_lt_w) begin
            // width shrank under the row: close it with what it holds
            state_nxt = spe_pkg::ST_ENC_START;
          end else if (sts_i.four) begin
            cmd_o.px_rd4 = 1'b1;
            state_nxt    = spe_pkg::ST_P4_WR;
          end else begin
            cmd_o.px_wr8 = 1'b1;
            if (sts_i.pc_last) begin
              state_nxt = spe_pkg::ST_ENC_START;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.res  = spe_pkg::RES_ZERO;
            end
          end
        end
      end
      spe_pkg::ST_P4_WR: begin
        cmd_o.px_wr4 = 1'b1;
        if (sts_i.pc_last) begin
          state_nxt = spe_pkg::ST_ENC_START;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = spe_pkg::RES_ZERO;
          state_nxt  = spe_pkg::ST_IDLE;
        end
      end
      spe_pkg::ST_ENC_START: begin
        cmd_o.enc_init = 1'b1;
        state_nxt      = spe_pkg::ST_FILL_A;
      end
      spe_pkg::ST_FILL_A: begin
        cmd_o.win_shift = 1'b1;
        state_nxt       = spe_pkg::ST_FILL_L;
      end
      spe_pkg::ST_FILL_L: begin
        cmd_o.win_load = 1'b1;
        if (!sts_i.fill_done) begin
          state_nxt = spe_pkg::ST_FILL_A;
        end else if (sts_i.kind == spe_pkg::K_RAW) begin
          state_nxt = spe_pkg::ST_RAW_WR;
        end else begin
          state_nxt = spe_pkg::ST_DEC;
        end
      end
      spe_pkg::ST_DEC: begin
        if (sts_i.triple) begin
          cmd_o.dec_run = 1'b1;
          state_nxt     = spe_pkg::ST_ADV;
        end else begin
          cmd_o.dec_lit = 1'b1;
          state_nxt     = spe_pkg::ST_LIT_WR;
        end
      end
      spe_pkg::ST_LIT_WR: begin
        cmd_o.lit_wr = 1'b1;
        state_nxt    = spe_pkg::ST_ADV;
      end
      spe_pkg::ST_RAW_WR: begin
        cmd_o.raw_wr = 1'b1;
        state_nxt    = spe_pkg::ST_ADV;
      end
      spe_pkg::ST_ADV: begin
        cmd_o.win_shift = 1'b1;
        cmd_o.pos_inc   = 1'b1;
        state_nxt       = spe_pkg::ST_LD;
      end
      spe_pkg::ST_LD: begin
        cmd_o.win_load = 1'b1;
        state_nxt      = spe_pkg::ST_CHK;
      end
      spe_pkg::ST_CHK: begin
        case (sts_i.kind)
          spe_pkg::K_RAW: begin
            state_nxt = sts_i.pos_lt_len ? spe_pkg::ST_RAW_WR : spe_pkg::ST_CLR_INIT;
          end
          spe_pkg::K_RUN: begin
            if (sts_i.pos_lt_len && sts_i.run_more) begin
              cmd_o.run_inc = 1'b1;
              state_nxt     = spe_pkg::ST_ADV;
            end else begin
              state_nxt = spe_pkg::ST_HDR;
            end
          end
          spe_pkg::K_LIT: begin
            // a literal stops before a triple of equal bytes
            if (sts_i.pos_lt_len && sts_i.cnt_lt_max && !sts_i.triple) begin
              state_nxt = spe_pkg::ST_LIT_WR;
            end else begin
              state_nxt = spe_pkg::ST_HDR;
            end
          end
          default: begin
            state_nxt = spe_pkg::ST_HDR;
          end
        endcase
      end
      spe_pkg::ST_HDR: begin
        cmd_o.hdr_wr = 1'b1;
        if (sts_i.kind == spe_pkg::K_RUN) begin
          state_nxt = spe_pkg::ST_VAL;
        end else begin
          state_nxt = sts_i.pos_lt_len ? spe_pkg::ST_DEC : spe_pkg::ST_CNT_HI;
        end
      end
      spe_pkg::ST_VAL: begin
        cmd_o.val_wr = 1'b1;
        state_nxt    = sts_i.pos_lt_len ? spe_pkg::ST_DEC : spe_pkg::ST_CNT_HI;
      end
      spe_pkg::ST_CNT_HI: begin
        cmd_o.cnt_hi = sts_i.wide;
        state_nxt    = spe_pkg::ST_CNT_LO;
      end
      spe_pkg::ST_CNT_LO: begin
        cmd_o.cnt_lo = 1'b1;
        state_nxt    = spe_pkg::ST_CLR_INIT;
      end
      spe_pkg::ST_CLR_INIT: begin
        cmd_o.clr_init = 1'b1;
        state_nxt      = spe_pkg::ST_CLR;
      end
      spe_pkg::ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = spe_pkg::ST_FIN;
        end
      end
      spe_pkg::ST_FIN: begin
        cmd_o.finish = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.res    = spe_pkg::RES_ZERO;
        state_nxt    = spe_pkg::ST_IDLE;
      end
      spe_pkg::ST_RD_TAKE: begin
        cmd_o.rd_take = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.res     = spe_pkg::RES_BYTE;
        state_nxt     = spe_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spe_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != spe_pkg::ST_IDLE);

`include "scanline_packbits_encoder_macros.svh"

  `SPE_ASSERT_NEXT(a_emit_ends_request, cmd_o.emit, state_r == spe_pkg::ST_IDLE)
  `SPE_ASSERT_NOW(a_dec_has_bytes, state_r == spe_pkg::ST_DEC, sts_i.pos_lt_len)

endmodule

[rtl/core/spe_dp.sv]
// Datapath: config, row store, byte window, packet build, output queue
module spe_dp #(
  parameter int MAX_LINE_BYTES = spe_pkg::MAX_LINE_BYTES_DEF,
  parameter int MAX_RUN        = spe_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  spe_pkg::cfg_idx_t              cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  spe_pkg::in_t                   in_data,
  input  spe_pkg::cmd_t                  cmd_i,
  output spe_pkg::sts_t                  sts_o,
  output logic                           out_valid,
  output spe_pkg::out_t                  out_data
);

  localparam int ROW_CAP   = MAX_LINE_BYTES - (MAX_LINE_BYTES % 2);
  localparam int OUT_DEPTH = ROW_CAP + (ROW_CAP + MAX_RUN - 1) / MAX_RUN + 2;
  localparam int RA    = $clog2(ROW_CAP);
  localparam int RBW   = $clog2(ROW_CAP + 1);
  localparam int RBW2  = RBW + 2;
  localparam int RCW   = $clog2(ROW_CAP + 4);
  localparam int PCW   = $clog2(2 * ROW_CAP + 1);
  localparam int PCW1  = PCW + 1;
  localparam int WW    = (PCW > spe_pkg::ROW_WIDTH_W) ? PCW : spe_pkg::ROW_WIDTH_W;
  localparam int OA    = $clog2(OUT_DEPTH);
  localparam int OLW   = $clog2(OUT_DEPTH + 1);
  localparam int CW    = $clog2(MAX_RUN + 1);
  localparam bit RUN_OK = (MAX_RUN >= 3);

  // config
  logic                            four_r;
  logic [spe_pkg::ROW_WIDTH_W-1:0] width_r;

  // control state
  logic [PCW-1:0] pc_r;
  logic [OLW-1:0] out_len_r;
  logic [OLW-1:0] rp_r;
  logic           pending_r;
  logic [RBW-1:0] hw_r;
  logic           out_valid_r;

  // encoder working registers
  logic [7:0]     pix_r;
  logic [7:0]     w0_r, w1_r, w2_r;
  logic [RBW-1:0] pos_r;
  logic [RCW-1:0] ra_r;
  logic [RBW-1:0] len_r;
  logic           wide_r;
  spe_pkg::kind_t kind_r;
  logic [CW-1:0]  cnt_r;
  logic [7:0]     val_r;
  logic [OLW-1:0] hdr_r;
  logic [OLW-1:0] o_r;
  spe_pkg::out_t  out_r;
  spe_pkg::out_t  out_nxt;

  // memories
  logic [7:0] row_mem [ROW_CAP];
  logic [7:0] out_mem [OUT_DEPTH];
  logic [7:0] row_rd_r;
  logic [7:0] out_rd_r;

  logic          row_we;
  logic [RA-1:0] row_wa, row_ra;
  logic [7:0]    row_wd;
  logic          out_we;
  logic [OA-1:0] out_wa;
  logic [7:0]    out_wd;

  // effective width and row byte count
  logic [WW-1:0]   w_raw, w_cap;
  logic [PCW-1:0]  w_eff;
  logic [PCW1-1:0] half_w;
  logic [RBW-1:0]  rb;
  logic [RA-1:0]   pc_byte, pc_flat, px_idx;
  logic [7:0]      nib;
  logic [RBW-1:0]  clr_end;
  logic [OLW-1:0]  lit_addr;
  logic [31:0]     n32;
  logic            rd_last;

  always_comb begin
    w_raw   = (width_r == '0) ? WW'(1) : WW'(width_r);
    w_cap   = four_r ? WW'(2 * ROW_CAP) : WW'(ROW_CAP);
    w_eff   = PCW'((w_raw > w_cap) ? w_cap : w_raw);
    half_w  = four_r ? ((PCW1'(w_eff) + 1'b1) >> 1) : PCW1'(w_eff);
    rb      = RBW'(half_w + PCW1'(half_w[0]));
    pc_byte = RA'(pc_r >> 1);
    pc_flat = RA'(pc_r);
    px_idx  = four_r ? pc_byte : pc_flat;
    nib     = pix_r & spe_pkg::NIBBLE_MASK;
    clr_end = (len_r > hw_r) ? len_r : hw_r;
    lit_addr = OLW'(hdr_r + OLW'(cnt_r) + 1'b1);
    n32     = 32'(o_r) - (wide_r ? 32'd2 : 32'd1);
    rd_last = (OLW'(rp_r + 1'b1) >= out_len_r);
  end

  always_comb begin
    sts_o.pending    = pending_r;
    sts_o.rd_ok      = pending_r && (rp_r < out_len_r);
    sts_o.pc_lt_w    = (pc_r < w_eff);
    sts_o.pc_last    = ((PCW1'(pc_r) + 1'b1) >= PCW1'(w_eff));
    sts_o.four       = four_r;
    sts_o.fill_done  = (ra_r == RCW'(3));
    sts_o.kind       = kind_r;
    sts_o.triple     = RUN_OK && ((RBW2'(pos_r) + 2'd2) < RBW2'(len_r)) &&
                       (w0_r == w1_r) && (w1_r == w2_r);
    sts_o.pos_lt_len = (pos_r < len_r);
    sts_o.cnt_lt_max = (32'(cnt_r) < MAX_RUN);
    sts_o.run_more   = (w0_r == val_r) && sts_o.cnt_lt_max;
    sts_o.wide       = wide_r;
    sts_o.clr_last   = ((ra_r + 1'b1) >= RCW'(clr_end));
  end

  // row store ports
  always_comb begin
    row_we = 1'b0;
    row_wa = RA'(ra_r);
    row_wd = '0;
    priority if (cmd_i.px_wr8) begin
      row_we = 1'b1;
      row_wa = pc_flat;
      row_wd = in_data.pixel_index;
    end else if (cmd_i.px_wr4) begin
      // high nibble first; nibbles are ORed into the byte
      row_we = 1'b1;
      row_wa = pc_byte;
      row_wd = pc_r[0] ? (row_rd_r | nib) : (row_rd_r | {nib[3:0], 4'b0000});
    end else if (cmd_i.clr_step) begin
      row_we = 1'b1;
    end
    row_ra = cmd_i.px_rd4 ? pc_byte : RA'(ra_r);
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_rd_r <= row_mem[row_ra];
  end

  // output queue ports
  always_comb begin
    out_we = 1'b1;
    out_wa = OA'(o_r);
    out_wd = w0_r;
    priority if (cmd_i.raw_wr) begin
      out_wa = OA'(o_r);
    end else if (cmd_i.lit_wr) begin
      out_wa = OA'(lit_addr);
    end else if (cmd_i.hdr_wr) begin
      out_wa = OA'(hdr_r);
      out_wd = (kind_r == spe_pkg::K_RUN) ? 8'(8'd1 - 8'(cnt_r)) : 8'(8'(cnt_r) - 8'd1);
    end else if (cmd_i.val_wr) begin
      out_wa = OA'(hdr_r + 1'b1);
      out_wd = val_r;
    end else if (cmd_i.cnt_hi) begin
      out_wa = '0;
      out_wd = n32[15:8];
    end else if (cmd_i.cnt_lo) begin
      out_wa = OA'(wide_r);
      out_wd = n32[7:0];
    end else begin
      out_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_wa] <= out_wd;
    end
    out_rd_r <= out_mem[OA'(rp_r)];
  end

  // result word for the request being finished
  always_comb begin
    out_nxt = '0;
    unique case (cmd_i.res)
      spe_pkg::RES_DROP: out_nxt.pixel_dropped = 1'b1;
      spe_pkg::RES_BYTE: begin
        out_nxt.byte_valid = 1'b1;
        out_nxt.out_byte   = out_rd_r;
        out_nxt.row_end    = rd_last;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_r      <= 1'b0;
      width_r     <= spe_pkg::ROW_WIDTH_RST;
      pc_r        <= '0;
      out_len_r   <= '0;
      rp_r        <= '0;
      pending_r   <= 1'b0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit;
      if (cfg_we) begin
        unique case (cfg_index)
          spe_pkg::CFG_FOUR_BIT_PIXELS: four_r  <= cfg_data[0];
          spe_pkg::CFG_ROW_WIDTH:       width_r <= cfg_data;
        endcase
      end
      if (cmd_i.px_wr8 || cmd_i.px_wr4) begin
        pc_r <= pc_r + 1'b1;
        if ((RBW'(px_idx) + 1'b1) > hw_r) begin
          hw_r <= RBW'(px_idx) + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        pc_r      <= '0;
        rp_r      <= '0;
        pending_r <= 1'b1;
        out_len_r <= o_r;
        hw_r      <= '0;
      end
      if (cmd_i.rd_take) begin
        rp_r <= rp_r + 1'b1;
        if (rd_last) begin
          pending_r <= 1'b0;
        end
      end
      if (cmd_i.rd_empty) begin
        pending_r <= 1'b0;
      end
    end
  end

  // encoder working registers
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      pix_r <= in_data.pixel_index;
    end
    if (cmd_i.enc_init) begin
      len_r  <= rb;
      wide_r <= (32'(rb) > spe_pkg::WIDE_LIMIT);
      kind_r <= (32'(rb) < spe_pkg::RAW_LIMIT) ? spe_pkg::K_RAW : spe_pkg::K_LIT;
      pos_r  <= '0;
      if (32'(rb) < spe_pkg::RAW_LIMIT) begin
        o_r <= '0;
      end else begin
        o_r <= (32'(rb) > spe_pkg::WIDE_LIMIT) ? OLW'(2) : OLW'(1);
      end
    end
    priority if (cmd_i.enc_init || cmd_i.clr_init) begin
      ra_r <= '0;
    end else if (cmd_i.win_shift || cmd_i.clr_step) begin
      ra_r <= ra_r + 1'b1;
    end
    if (cmd_i.win_shift) begin
      w0_r <= w1_r;
      w1_r <= w2_r;
    end
    if (cmd_i.pos_inc) begin
      pos_r <= pos_r + 1'b1;
    end
    if (cmd_i.win_load) begin
      w2_r <= row_rd_r;
    end
    if (cmd_i.dec_run) begin
      kind_r <= spe_pkg::K_RUN;
      cnt_r  <= CW'(1);
      val_r  <= w0_r;
      hdr_r  <= o_r;
    end
    if (cmd_i.dec_lit) begin
      kind_r <= spe_pkg::K_LIT;
      cnt_r  <= '0;
      hdr_r  <= o_r;
    end
    if (cmd_i.lit_wr || cmd_i.run_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd_i.raw_wr) begin
      o_r <= o_r + 1'b1;
    end
    if (cmd_i.hdr_wr && (kind_r == spe_pkg::K_LIT)) begin
      o_r <= lit_addr;
    end
    if (cmd_i.val_wr) begin
      o_r <= OLW'(hdr_r + 2'd2);
    end
    if (cmd_i.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "scanline_packbits_encoder_macros.svh"

  `SPE_ASSERT_NOW(a_pending_has_bytes, pending_r, rp_r < out_len_r)
  `SPE_ASSERT_NEXT(a_pixel_counted, cmd_i.px_wr8 || cmd_i.px_wr4, pc_r == $past(pc_r) + 1'b1)

endmodule
